// ===== design/bdepq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdepq_pkg
// Shared types for the bounded double-ended priority queue: operation codes,
// the command that drives the rows of cells, and the controller states.
// ----------------------------------------------------------------------------
package bdepq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MIN = 2'd1,
    OP_DEL_MAX = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_REINS = 2'd2
  } state_e;

endpackage

// ===== design/bounded_double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_priority_queue
// Keeps up to CAPACITY signed keys, each named by a handle, and serves
// insert, delete-min, delete-max and remove-by-handle.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (op_i, key_i, handle_i) is taken at a clock edge where
//   start is high and busy is low. Exactly one result word follows on
//   result_handle_o, marked by result_valid_o for a single cycle; there is
//   no back-pressure, so the receiver must take it then.
//   An accepted word first reads the free-handle stack and the key memory,
//   whose read data is registered; the controller's execute state then
//   shifts the two sorted rows of cells (one ascending for the minimum, one
//   descending for the maximum). An insert into a full store that evicts
//   the largest key shifts them twice, passing through a reinsert state.
//   busy is high in the execute and reinsert states, so a new word is not
//   taken while one is in progress; the result strobe is registered.
//   A new command may be taken in the cycle the result strobe is shown.
//   Reset empties both rows and returns the free stack to 1..CAPACITY with
//   CAPACITY on top; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_double_ended_priority_queue #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned HW      = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] key_i,
  input  logic [HW-1:0]      handle_i,
  output logic               result_valid_o,
  output logic [HW-1:0]      result_handle_o
);
  import bdepq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e             state_q, state_d;
  op_e                op_q;
  logic signed [31:0] key_q;
  logic [HW-1:0]      hdl_q;
  logic [HW-1:0]      evh_q;

  logic [CAPACITY-1:0] occ_q;
  logic                rdocc_q;
  logic signed [31:0]  kmem [CAPACITY];
  logic signed [31:0]  rdkey_q;

  logic               res_v_q, res_v_d;
  logic [HW-1:0]      res_h_q, res_h_d;

  cmd_e               cmd;
  logic signed [31:0] cmd_key;
  logic [HW-1:0]      cmd_hdl;

  logic               a_v, b_v;
  logic signed [31:0] a_k, b_k;
  logic [HW-1:0]      a_h, b_h;

  logic               pop, push;
  logic [HW-1:0]      push_hdl;
  logic [HW-1:0]      stk_top;
  logic               stk_empty;

  logic               kwr;
  logic [HW-1:0]      kwr_hdl;
  logic               occ_set, occ_clr;
  logic [HW-1:0]      occ_hdl;
  logic               evict;
  logic               accept;

  logic [HW-1:0]      in_hm1, kwr_hm1, occ_hm1;
  logic               rm_hit;

  assign accept  = start && !busy;
  assign in_hm1  = handle_i - HW'(1);
  assign kwr_hm1 = kwr_hdl - HW'(1);
  assign occ_hm1 = occ_hdl - HW'(1);

  assign rm_hit = (hdl_q != '0) && (hdl_q <= HW'(CAPACITY)) && rdocc_q;
  assign evict  = (state_q == ST_EXEC) && (op_q == OP_INSERT) && stk_empty
                  && b_v && (key_q < b_k);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  state_d = evict ? ST_REINS : ST_IDLE;
      ST_REINS: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    cmd      = CMD_HOLD;
    cmd_key  = key_q;
    cmd_hdl  = hdl_q;
    pop      = 1'b0;
    push     = 1'b0;
    push_hdl = hdl_q;
    kwr      = 1'b0;
    kwr_hdl  = hdl_q;
    occ_set  = 1'b0;
    occ_clr  = 1'b0;
    occ_hdl  = hdl_q;
    res_v_d  = 1'b0;
    res_h_d  = '0;
    unique case (state_q)
      ST_EXEC: begin
        res_v_d = 1'b1;
        unique case (op_q)
          OP_INSERT: begin
            if (!stk_empty) begin
              cmd     = CMD_INSERT;
              cmd_hdl = stk_top;
              pop     = 1'b1;
              kwr     = 1'b1;
              kwr_hdl = stk_top;
              occ_set = 1'b1;
              occ_hdl = stk_top;
              res_h_d = stk_top;
            end else if (evict) begin
              // drop the largest entry now, put the new key in next cycle
              cmd     = CMD_REMOVE;
              cmd_key = b_k;
              cmd_hdl = b_h;
              res_v_d = 1'b0;
            end
          end
          OP_DEL_MIN: begin
            if (a_v) begin
              cmd      = CMD_REMOVE;
              cmd_key  = a_k;
              cmd_hdl  = a_h;
              push     = 1'b1;
              push_hdl = a_h;
              occ_clr  = 1'b1;
              occ_hdl  = a_h;
              res_h_d  = a_h;
            end
          end
          OP_DEL_MAX: begin
            if (b_v) begin
              cmd      = CMD_REMOVE;
              cmd_key  = b_k;
              cmd_hdl  = b_h;
              push     = 1'b1;
              push_hdl = b_h;
              occ_clr  = 1'b1;
              occ_hdl  = b_h;
              res_h_d  = b_h;
            end
          end
          OP_REMOVE: begin
            if (rm_hit) begin
              cmd      = CMD_REMOVE;
              cmd_key  = rdkey_q;
              cmd_hdl  = hdl_q;
              push     = 1'b1;
              push_hdl = hdl_q;
              occ_clr  = 1'b1;
              occ_hdl  = hdl_q;
              res_h_d  = hdl_q;
            end
          end
          default: begin
          end
        endcase
      end
      ST_REINS: begin
        cmd     = CMD_INSERT;
        cmd_hdl = evh_q;
        kwr     = 1'b1;
        kwr_hdl = evh_q;
        res_v_d = 1'b1;
        res_h_d = evh_q;
      end
      ST_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_v_q <= 1'b0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
      if (occ_set) begin
        occ_q[occ_hm1[AW-1:0]] <= 1'b1;
      end else if (occ_clr) begin
        occ_q[occ_hm1[AW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      key_q <= key_i;
      hdl_q <= handle_i;
    end
    if (evict) begin
      evh_q <= b_h;
    end
    res_h_q <= res_h_d;
    rdocc_q <= occ_q[in_hm1[AW-1:0]];
  end

  // key memory, indexed by handle - 1; read address follows the input port
  always_ff @(posedge clk_i) begin
    if (kwr) begin
      kmem[kwr_hm1[AW-1:0]] <= key_q;
    end
    rdkey_q <= kmem[in_hm1[AW-1:0]];
  end

  assign result_valid_o  = res_v_q;
  assign result_handle_o = res_h_q;

  // ---------------------------------------------------------------- datapath
  bdepq_fstack #(
    .CAPACITY (CAPACITY)
  ) u_fstack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_i      (pop),
    .push_i     (push),
    .push_hdl_i (push_hdl),
    .top_o      (stk_top),
    .empty_o    (stk_empty)
  );

  bdepq_chain #(
    .CAPACITY (CAPACITY),
    .DESC     (1'b0)
  ) u_min_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cmd_key_i (cmd_key),
    .cmd_hdl_i (cmd_hdl),
    .head_v_o  (a_v),
    .head_k_o  (a_k),
    .head_h_o  (a_h)
  );

  bdepq_chain #(
    .CAPACITY (CAPACITY),
    .DESC     (1'b1)
  ) u_max_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cmd_key_i (cmd_key),
    .cmd_hdl_i (cmd_hdl),
    .head_v_o  (b_v),
    .head_k_o  (b_k),
    .head_h_o  (b_h)
  );

endmodule

// ===== design/bdepq_cell.sv =====
// ----------------------------------------------------------------------------
// bdepq_cell
// One cell of a sorted row. Holds one (key, handle) entry and on each command
// either keeps it, takes the left neighbour's, takes the new entry or takes
// the right neighbour's, deciding from local compares only.
// ----------------------------------------------------------------------------
module bdepq_cell #(
  parameter int unsigned HW    = 7,
  parameter bit          DESC  = 1'b0,
  parameter bit          FIRST = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bdepq_pkg::cmd_e      cmd_i,
  input  logic signed [31:0]   cmd_key_i,
  input  logic [HW-1:0]        cmd_hdl_i,
  input  logic                 left_v_i,
  input  logic signed [31:0]   left_k_i,
  input  logic [HW-1:0]        left_h_i,
  input  logic                 right_v_i,
  input  logic signed [31:0]   right_k_i,
  input  logic [HW-1:0]        right_h_i,
  output logic                 v_o,
  output logic signed [31:0]   k_o,
  output logic [HW-1:0]        h_o
);
  import bdepq_pkg::*;

  logic               v_q, v_d;
  logic signed [31:0] k_q, k_d;
  logic [HW-1:0]      h_q, h_d;

  // row order: key rising (falling when DESC), then lowest handle first
  function automatic logic prec(logic signed [31:0] ka, logic [HW-1:0] ha,
                                logic signed [31:0] kb, logic [HW-1:0] hb);
    logic kfirst;
    kfirst = DESC ? (ka > kb) : (ka < kb);
    return kfirst || ((ka == kb) && (ha < hb));
  endfunction

  always_comb begin
    v_d = v_q;
    k_d = k_q;
    h_d = h_q;
    unique case (cmd_i)
      CMD_INSERT: begin
        if (!FIRST && (!left_v_i || prec(cmd_key_i, cmd_hdl_i, left_k_i, left_h_i))) begin
          v_d = left_v_i;
          k_d = left_k_i;
          h_d = left_h_i;
        end else if (!v_q || prec(cmd_key_i, cmd_hdl_i, k_q, h_q)) begin
          v_d = 1'b1;
          k_d = cmd_key_i;
          h_d = cmd_hdl_i;
        end
      end
      CMD_REMOVE: begin
        // everything from the target onwards closes up by one
        if (!v_q || !prec(k_q, h_q, cmd_key_i, cmd_hdl_i)) begin
          v_d = right_v_i;
          k_d = right_k_i;
          h_d = right_h_i;
        end
      end
      CMD_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    h_q <= h_d;
  end

  assign v_o = v_q;
  assign k_o = k_q;
  assign h_o = h_q;

endmodule

// ===== design/bdepq_chain.sv =====
// ----------------------------------------------------------------------------
// bdepq_chain
// A row of CAPACITY cells kept sorted. The head cell holds the minimum entry
// (or the maximum when DESC is set); empty cells gather at the tail.
// ----------------------------------------------------------------------------
module bdepq_chain #(
  parameter int unsigned CAPACITY = 64,
  parameter bit          DESC     = 1'b0,
  localparam int unsigned HW      = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bdepq_pkg::cmd_e      cmd_i,
  input  logic signed [31:0]   cmd_key_i,
  input  logic [HW-1:0]        cmd_hdl_i,
  output logic                 head_v_o,
  output logic signed [31:0]   head_k_o,
  output logic [HW-1:0]        head_h_o
);
  import bdepq_pkg::*;

  logic               cv [CAPACITY];
  logic signed [31:0] ck [CAPACITY];
  logic [HW-1:0]      ch [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               lv, rv;
    logic signed [31:0] lk, rk;
    logic [HW-1:0]      lh, rh;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lk = '0;
      assign lh = '0;
    end else begin : g_mid_l
      assign lv = cv[i-1];
      assign lk = ck[i-1];
      assign lh = ch[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = 1'b0;
      assign rk = '0;
      assign rh = '0;
    end else begin : g_mid_r
      assign rv = cv[i+1];
      assign rk = ck[i+1];
      assign rh = ch[i+1];
    end

    bdepq_cell #(
      .HW    (HW),
      .DESC  (DESC),
      .FIRST (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .cmd_key_i (cmd_key_i),
      .cmd_hdl_i (cmd_hdl_i),
      .left_v_i  (lv),
      .left_k_i  (lk),
      .left_h_i  (lh),
      .right_v_i (rv),
      .right_k_i (rk),
      .right_h_i (rh),
      .v_o       (cv[i]),
      .k_o       (ck[i]),
      .h_o       (ch[i])
    );
  end

  assign head_v_o = cv[0];
  assign head_k_o = ck[0];
  assign head_h_o = ch[0];

endmodule

// ===== design/bdepq_fstack.sv =====
// ----------------------------------------------------------------------------
// bdepq_fstack
// LIFO of free handles in a memory. After reset entry j reads as j+1: a low
// water mark tracks how far the stack has been popped, and entries below it
// have never been written since reset. The top is read every cycle.
// ----------------------------------------------------------------------------
module bdepq_fstack #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned HW      = $clog2(CAPACITY + 1),
  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_i,
  input  logic          push_i,
  input  logic [HW-1:0] push_hdl_i,
  output logic [HW-1:0] top_o,
  output logic          empty_o
);
  logic [HW-1:0] mem [CAPACITY];
  logic [HW-1:0] cnt_q, cnt_d;
  logic [HW-1:0] lw_q, lw_d;
  logic [HW-1:0] rd_q;
  logic [HW-1:0] init_q;
  logic          use_init_q;
  logic [HW-1:0] cnt_m1;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  assign cnt_m1 = cnt_q - HW'(1);
  assign raddr  = cnt_m1[AW-1:0];
  assign waddr  = cnt_q[AW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    lw_d  = lw_q;
    if (pop_i) begin
      cnt_d = cnt_m1;
      if (cnt_m1 < lw_q) begin
        lw_d = cnt_m1;
      end
    end else if (push_i) begin
      cnt_d = cnt_q + HW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= HW'(CAPACITY);
      lw_q  <= HW'(CAPACITY);
    end else begin
      cnt_q <= cnt_d;
      lw_q  <= lw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[waddr] <= push_hdl_i;
    end
    rd_q       <= mem[raddr];
    init_q     <= cnt_q;
    use_init_q <= (cnt_m1 < lw_q);
  end

  // below the low water mark an entry still holds its reset value j+1
  assign top_o   = use_init_q ? init_q : rd_q;
  assign empty_o = (cnt_q == '0);

endmodule
